// File: hw/rtl/u8u16_pkg.sv
// Types and constants shared by the UTF-8 to UTF-16 converter and its checker.
package u8u16_pkg;

  typedef enum logic [1:0] {
    KIND_UNIT    = 2'd0,
    KIND_TERM    = 2'd1,
    KIND_INVALID = 2'd2,
    KIND_UNENC   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_string;
  } in_word_t;

  typedef struct packed {
    logic [15:0] code_unit;
    kind_e       result_kind;
    logic        last_of_string;
  } out_word_t;

  localparam int unsigned CpW     = 21;
  localparam int unsigned MaxRes  = 3;
  localparam int unsigned ResCntW = 2;

  localparam logic [CpW-1:0] CP_MAX    = 21'h10FFFF;
  localparam logic [CpW-1:0] SUPP_BASE = 21'h010000;
  localparam logic [CpW-1:0] SURR_LO   = 21'h00D800;
  localparam logic [CpW-1:0] SURR_HI   = 21'h00DFFF;

  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;
  localparam logic [5:0] HI_TAG    = 6'b110110;
  localparam logic [5:0] LO_TAG    = 6'b110111;

endpackage

// File: hw/rtl/utf8_to_utf16_stream_converter_unit.sv
// UTF-8 to UTF-16 stream converter: input register, decode logic and result buffer.
//
//   channel | valid       | stall        | word
//   --------+-------------+--------------+-------------------------------
//   input   | in_valid_i  | in_stall_o   | in_word_i  (u8u16_pkg::in_word_t)
//   output  | out_valid_o | out_stall_i  | out_word_o (u8u16_pkg::out_word_t)
//
// An accepted byte is registered, decoded combinationally, and its results land
// in a registered three-entry result buffer. One byte per cycle is taken while
// each byte gives at most one result and the output is not stalled; a byte with
// more results holds the input until its last result leaves the single output port.
// Reset clears the decoder state and both valid flags; the next string starts clean.
// A stalled output holds the buffer, which in turn stalls the input register.
module utf8_to_utf16_stream_converter_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  u8u16_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output u8u16_pkg::out_word_t out_word_o
);
  import u8u16_pkg::*;

  logic                 in_valid_q;
  in_word_t             in_q;
  logic [CpW-1:0]       part_q, part_d;
  logic [1:0]           need_q, need_d;
  logic                 err_q, err_d;
  out_word_t            res_q [MaxRes];
  out_word_t            res_d [MaxRes];
  logic [ResCntW-1:0]   rem_q;
  logic [ResCntW-1:0]   n_d;
  logic                 pop, free, advance;

  assign out_valid_o = (rem_q != '0);
  assign out_word_o  = res_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  assign free        = (rem_q == '0) || ((rem_q == ResCntW'(1)) && pop);
  assign advance     = in_valid_q && free;
  assign in_stall_o  = in_valid_q && !free;

  always_comb begin
    logic [7:0]     b;
    logic [CpW-1:0] cp;
    logic [CpW-1:0] off;
    logic           bad;
    logic           unenc;
    b       = in_q.data_byte;
    cp      = '0;
    off     = '0;
    bad     = 1'b0;
    unenc   = 1'b0;
    part_d  = part_q;
    need_d  = need_q;
    err_d   = err_q;
    n_d     = '0;
    for (int i = 0; i < MaxRes; i++) begin
      res_d[i] = '{code_unit: '0, result_kind: KIND_UNIT, last_of_string: 1'b0};
    end

    if (in_q.byte_present && !err_q) begin
      if (need_q == 2'd0) begin
        priority if (!b[7]) begin
          res_d[n_d].code_unit = {8'h00, b};
          n_d = n_d + ResCntW'(1);
        end else if (b[7:5] == LEAD2_TAG) begin
          part_d = {16'b0, b[4:0]};
          need_d = 2'd1;
        end else if (b[7:4] == LEAD3_TAG) begin
          part_d = {17'b0, b[3:0]};
          need_d = 2'd2;
        end else if (b[7:3] == LEAD4_TAG) begin
          part_d = {18'b0, b[2:0]};
          need_d = 2'd3;
        end else begin
          bad = 1'b1;
        end
      end else begin
        cp     = {part_q[CpW-7:0], b[5:0]};
        part_d = cp;
        need_d = need_q - 2'd1;
        if (need_d == 2'd0) begin
          part_d = '0;
          priority if (cp > CP_MAX) begin
            bad = 1'b1;
          end else if (cp >= SURR_LO && cp <= SURR_HI) begin
            unenc = 1'b1;
          end else if (cp < SUPP_BASE) begin
            res_d[n_d].code_unit = cp[15:0];
            n_d = n_d + ResCntW'(1);
          end else begin
            off = cp - SUPP_BASE;
            res_d[n_d].code_unit = {HI_TAG, off[19:10]};
            n_d = n_d + ResCntW'(1);
            res_d[n_d].code_unit = {LO_TAG, off[9:0]};
            n_d = n_d + ResCntW'(1);
          end
        end
      end
    end

    if (bad || unenc) begin
      err_d  = 1'b1;
      need_d = 2'd0;
      part_d = '0;
      res_d[n_d].result_kind = unenc ? KIND_UNENC : KIND_INVALID;
      n_d = n_d + ResCntW'(1);
    end

    if (in_q.end_of_string) begin
      if (!err_d && need_d != 2'd0) begin
        res_d[n_d].result_kind = KIND_INVALID;
        n_d = n_d + ResCntW'(1);
      end
      res_d[n_d].result_kind    = KIND_TERM;
      res_d[n_d].last_of_string = 1'b1;
      n_d    = n_d + ResCntW'(1);
      part_d = '0;
      need_d = 2'd0;
      err_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
      need_q <= 2'd0;
      err_q  <= 1'b0;
    end else if (advance) begin
      part_q <= part_d;
      need_q <= need_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (advance) begin
      rem_q <= n_d;
    end else if (pop) begin
      rem_q <= rem_q - ResCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end else if (pop) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

endmodule

// File: hw/rtl/u8u16_checker.sv
// Port-level checks for the UTF-8 to UTF-16 converter and their binding.
module u8u16_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input u8u16_pkg::in_word_t  in_word_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input u8u16_pkg::out_word_t out_word_o
);
  import u8u16_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word dropped or changed while stalled");

  a_last_is_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.last_of_string == (out_word_o.result_kind == KIND_TERM)))
    else $error("last flag does not match terminator kind");

  a_zero_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.result_kind != KIND_UNIT) |-> (out_word_o.code_unit == '0))
    else $error("non-unit result carries a code unit");

  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty result buffer");

endmodule

bind utf8_to_utf16_stream_converter_unit u8u16_checker u_u8u16_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

// File: test/utf8_to_utf16_stream_converter_unit_tb.sv
// Self-checking testbench for the UTF-8 to UTF-16 stream converter unit.
`timescale 1ns / 1ps

module utf8_to_utf16_stream_converter_unit_tb;
  import u8u16_pkg::*;

  localparam int unsigned RandomBytes = 105;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldStart   = 60;
  localparam int unsigned HoldLen     = 60;
  localparam int unsigned QuietFrom   = 130;
  localparam int unsigned QuietTo     = 200;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned ReportMax   = 10;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  in_word_t  pending_q[$];
  out_word_t unit_q[$];

  logic [CpW-1:0] cp_acc   = '0;
  logic [1:0]     need_cnt = '0;
  logic           err_flag = 1'b0;

  int unsigned cycle_cnt    = 0;
  int unsigned hold_cnt     = 0;
  int unsigned stim_cnt     = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned string_cnt   = 0;
  int unsigned pair_cnt     = 0;
  int unsigned bad_seq_cnt  = 0;

  logic quiet;
  assign quiet = (cycle_cnt >= QuietFrom) && (cycle_cnt < QuietTo);

  utf8_to_utf16_stream_converter_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic void push_unit(logic [15:0] unit, kind_e kind, logic last);
    out_word_t r;
    r.code_unit      = unit;
    r.result_kind    = kind;
    r.last_of_string = last;
    unit_q.push_back(r);
  endfunction

  function automatic void flag_bad(kind_e kind);
    err_flag = 1'b1;
    need_cnt = '0;
    cp_acc   = '0;
    bad_seq_cnt++;
    push_unit('0, kind, 1'b0);
  endfunction

  function automatic void finish_cp(logic [CpW-1:0] cp);
    logic [CpW-1:0] off;
    if (cp > CP_MAX) begin
      flag_bad(KIND_INVALID);
    end else if (cp >= SURR_LO && cp <= SURR_HI) begin
      flag_bad(KIND_UNENC);
    end else if (cp < SUPP_BASE) begin
      push_unit(cp[15:0], KIND_UNIT, 1'b0);
    end else begin
      off = cp - SUPP_BASE;
      push_unit(16'hD800 + 16'(off[19:10]), KIND_UNIT, 1'b0);
      push_unit(16'hDC00 + 16'(off[9:0]), KIND_UNIT, 1'b0);
      pair_cnt++;
    end
  endfunction

  function automatic void predict_word(in_word_t w);
    logic [7:0]     b;
    logic [CpW-1:0] done_cp;
    b = w.data_byte;
    if (w.byte_present && !err_flag) begin
      if (need_cnt == 2'd0) begin
        if (!b[7]) begin
          push_unit({8'h00, b}, KIND_UNIT, 1'b0);
        end else if (b[7:5] == LEAD2_TAG) begin
          cp_acc   = CpW'(b[4:0]);
          need_cnt = 2'd1;
        end else if (b[7:4] == LEAD3_TAG) begin
          cp_acc   = CpW'(b[3:0]);
          need_cnt = 2'd2;
        end else if (b[7:3] == LEAD4_TAG) begin
          cp_acc   = CpW'(b[2:0]);
          need_cnt = 2'd3;
        end else begin
          flag_bad(KIND_INVALID);
        end
      end else begin
        cp_acc   = {cp_acc[CpW-7:0], b[5:0]};
        need_cnt = need_cnt - 2'd1;
        if (need_cnt == 2'd0) begin
          done_cp = cp_acc;
          cp_acc  = '0;
          finish_cp(done_cp);
        end
      end
    end
    if (w.end_of_string) begin
      if (!err_flag && need_cnt != 2'd0) begin
        flag_bad(KIND_INVALID);
      end
      push_unit('0, KIND_TERM, 1'b1);
      cp_acc   = '0;
      need_cnt = '0;
      err_flag = 1'b0;
      string_cnt++;
    end
  endfunction

  task automatic put_byte(logic [7:0] b, logic eos);
    in_word_t w;
    w.data_byte     = b;
    w.byte_present  = 1'b1;
    w.end_of_string = eos;
    pending_q.push_back(w);
    stim_cnt++;
  endtask

  task automatic put_end();
    in_word_t w;
    w.data_byte     = 8'($urandom);
    w.byte_present  = 1'b0;
    w.end_of_string = 1'b1;
    pending_q.push_back(w);
    stim_cnt++;
  endtask

  task automatic put_idle_item();
    in_word_t w;
    w.data_byte     = 8'($urandom);
    w.byte_present  = 1'b0;
    w.end_of_string = 1'b0;
    pending_q.push_back(w);
  endtask

  task automatic close_string();
    in_word_t w;
    if (pending_q.size() != 0 && !pending_q[$].end_of_string && $urandom_range(0, 2) != 0) begin
      w = pending_q.pop_back();
      w.end_of_string = 1'b1;
      pending_q.push_back(w);
    end else begin
      put_end();
    end
  endtask

  function automatic int unsigned enc_len(logic [CpW-1:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  function automatic logic [CpW-1:0] rand_cp();
    case ($urandom_range(0, 19))
      0, 1, 2, 3:      return CpW'($urandom_range(0, 'h7F));
      4, 5, 6, 7:      return CpW'($urandom_range('h80, 'h7FF));
      8, 9, 10, 11,
      12:              return CpW'($urandom_range('h800, 'hFFFF));
      13:              return CpW'($urandom_range('hD800, 'hDFFF));
      14, 15, 16, 17,
      18:              return CpW'($urandom_range('h10000, 'h10FFFF));
      default:         return CpW'($urandom_range('h10FFFF, 'h1FFFFF));
    endcase
  endfunction

  // Emit the first keep bytes of a len-byte encoding of cp.
  task automatic put_cp(logic [CpW-1:0] cp, int unsigned len, int unsigned keep);
    logic [7:0] b;
    logic [1:0] tag;
    for (int unsigned i = 0; i < keep; i++) begin
      if (i == 0) begin
        case (len)
          1:       b = {1'b0, cp[6:0]};
          2:       b = {LEAD2_TAG, cp[10:6]};
          3:       b = {LEAD3_TAG, cp[15:12]};
          default: b = {LEAD4_TAG, cp[20:18]};
        endcase
      end else begin
        tag = ($urandom_range(0, 19) == 0) ? 2'($urandom) : 2'b10;
        b   = {tag, cp[6*(len-1-i) +: 6]};
      end
      put_byte(b, 1'b0);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_word(in_word);
      end
      if (pending_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 9)) begin
        in_valid <= 1'b1;
        in_word  <= pending_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt - 1;
    end else if (cycle_cnt == HoldStart) begin
      out_stall <= 1'b1;
      hold_cnt  <= HoldLen;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 9);
    end
  end

  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid && !out_stall) begin
      checked_cnt++;
      if (unit_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= ReportMax) begin
          $display("[%0t] unexpected word: unit %h kind %0d last %b", $realtime,
                   out_word.code_unit, out_word.result_kind, out_word.last_of_string);
        end
      end else begin
        exp_w = unit_q.pop_front();
        if (out_word.code_unit !== exp_w.code_unit ||
            out_word.result_kind !== exp_w.result_kind ||
            out_word.last_of_string !== exp_w.last_of_string) begin
          mismatch_cnt++;
          if (mismatch_cnt <= ReportMax) begin
            $display("[%0t] mismatch: unit %h/%h kind %0d/%0d last %b/%b (exp/act)",
                     $realtime, exp_w.code_unit, out_word.code_unit, exp_w.result_kind,
                     out_word.result_kind, exp_w.last_of_string, out_word.last_of_string);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, unit_q.size());
      $display("** utf8_to_utf16_stream_converter_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned    first_rand;
    int unsigned    pick;
    int unsigned    len;
    logic [CpW-1:0] cp;

    put_end();
    put_byte(8'h00, 1'b1);
    put_byte(8'h7F, 1'b0);
    put_byte(8'hDF, 1'b0);
    put_byte(8'hBF, 1'b0);
    put_byte(8'hF4, 1'b0);
    put_byte(8'h8F, 1'b0);
    put_byte(8'hBF, 1'b0);
    put_byte(8'hBF, 1'b1);
    put_byte(8'hED, 1'b0);
    put_byte(8'hA0, 1'b0);
    put_byte(8'h80, 1'b0);
    put_byte(8'h41, 1'b1);
    put_byte(8'hF4, 1'b0);
    put_byte(8'h90, 1'b0);
    put_byte(8'h80, 1'b0);
    put_byte(8'h80, 1'b1);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h41, 1'b1);
    put_byte(8'hE2, 1'b0);
    put_byte(8'h82, 1'b1);
    put_byte(8'h80, 1'b1);

    first_rand = stim_cnt;
    while (stim_cnt < first_rand + RandomBytes) begin
      repeat ($urandom_range(0, 6)) begin
        pick = $urandom_range(0, 99);
        if (pick < 88) begin
          cp  = rand_cp();
          len = enc_len(cp);
          if ($urandom_range(0, 6) == 0) begin
            len = $urandom_range(len, 4);
          end
          put_cp(cp, len, len);
        end else if (pick < 93) begin
          put_byte(8'($urandom), 1'b0);
        end else if (pick < 97) begin
          cp  = rand_cp();
          len = (enc_len(cp) < 2) ? 2 : enc_len(cp);
          put_cp(cp, len, $urandom_range(1, len - 1));
        end else begin
          put_idle_item();
        end
      end
      close_string();
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || in_valid) @(posedge clk_i);
    while (unit_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d strings over %0d input words; checked %0d output words.",
             string_cnt, stim_cnt, checked_cnt);
    $display("Seen %0d surrogate pairs and %0d invalid or unencodable sequences.",
             pair_cnt, bad_seq_cnt);
    if (mismatch_cnt == 0) begin
      $display("** utf8_to_utf16_stream_converter_unit: PASSED **");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("** utf8_to_utf16_stream_converter_unit: FAILED **");
    end
    $finish;
  end

endmodule

// File: utf8_to_utf16_stream_converter_unit.f
hw/rtl/u8u16_pkg.sv
hw/rtl/utf8_to_utf16_stream_converter_unit.sv
hw/rtl/u8u16_checker.sv
test/utf8_to_utf16_stream_converter_unit_tb.sv
